// File: rtl/mmac_pkg.sv
// Package for the memory map attribute coalescer.
// Holds payload structs, register indexes and attribute constants.
// Used by every RTL file of the block; depends on nothing.
`default_nettype none
package mmac_pkg;

   localparam int PAGE_SHIFT = 12;
   localparam logic [63:0] ATTR_XP = 64'h0000_0000_0000_4000;
   localparam logic [63:0] ATTR_RO = 64'h0000_0000_0002_0000;
   localparam logic [31:0] RUNTIME_CODE_RESET = 32'd5;

   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   typedef enum logic [0:0] {
      CSR_PROTECT_ENABLE    = 1'b0,
      CSR_RUNTIME_CODE_TYPE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [31:0] mem_type;
      logic [63:0] attr_bits;
      logic [63:0] phys_start;
      logic [63:0] page_count;
      logic        last_entry;
   } req_type;

   typedef struct packed {
      logic [31:0] out_type;
      logic [63:0] out_attr;
      logic [63:0] out_start;
      logic [63:0] out_pages;
      logic        out_last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage
`default_nettype wire

// File: rtl/mmac_core.sv
// Input register, attribute enforcement and merge against the pending descriptor.
// Also holds the configuration registers. Depends on mmac_pkg.
`default_nettype none
module mmac_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire mmac_pkg::req_type       req_data,
   input  wire logic                    csr_we,
   input  wire mmac_pkg::csr_index_type csr_addr,
   input  wire logic [31:0]             csr_wdata,
   input  wire logic                    room,
   output mmac_pkg::push_type           push
);

   logic              in_valid_ff, in_valid_in;
   mmac_pkg::req_type in_data_ff;
   logic              protect_ff;
   logic [31:0]       rtc_type_ff;

   logic              pend_valid_ff, pend_valid_in;
   logic [31:0]       pend_type_ff, pend_type_in;
   logic [63:0]       pend_attr_ff, pend_attr_in;
   logic [63:0]       pend_start_ff, pend_start_in;
   logic [63:0]       pend_pages_ff, pend_pages_in;

   logic              go;
   logic [63:0]       attr_eff;
   logic [63:0]       pend_end;
   logic              merge;
   logic              emit_old;
   mmac_pkg::rsp_type old_rsp;
   mmac_pkg::rsp_type new_rsp;
   mmac_pkg::rsp_type pass_rsp;

   assign go        = in_valid_ff & room;
   assign req_ready = ~in_valid_ff | room;
   assign in_valid_in = req_valid & req_ready ? 1'b1 : (go ? 1'b0 : in_valid_ff);

   assign attr_eff = (in_data_ff.attr_bits != 64'd0) ? in_data_ff.attr_bits :
                     (in_data_ff.mem_type == rtc_type_ff) ? mmac_pkg::ATTR_RO :
                     mmac_pkg::ATTR_XP;
   assign pend_end = pend_start_ff + (pend_pages_ff << mmac_pkg::PAGE_SHIFT);
   assign merge    = pend_valid_ff && (in_data_ff.mem_type == pend_type_ff) &&
                     (attr_eff == pend_attr_ff) && (pend_end == in_data_ff.phys_start);
   assign emit_old = pend_valid_ff & ~merge;

   always_comb begin
      old_rsp.out_type  = pend_type_ff;
      old_rsp.out_attr  = pend_attr_ff;
      old_rsp.out_start = pend_start_ff;
      old_rsp.out_pages = pend_pages_ff;
      old_rsp.out_last  = 1'b0;

      pass_rsp.out_type  = in_data_ff.mem_type;
      pass_rsp.out_attr  = in_data_ff.attr_bits;
      pass_rsp.out_start = in_data_ff.phys_start;
      pass_rsp.out_pages = in_data_ff.page_count;
      pass_rsp.out_last  = in_data_ff.last_entry;

      pend_valid_in = pend_valid_ff;
      pend_type_in  = pend_type_ff;
      pend_attr_in  = pend_attr_ff;
      pend_start_in = pend_start_ff;
      pend_pages_in = pend_pages_ff;
      push          = '0;

      if (merge) begin
         pend_pages_in = pend_pages_ff + in_data_ff.page_count;
      end else begin
         pend_type_in  = in_data_ff.mem_type;
         pend_attr_in  = attr_eff;
         pend_start_in = in_data_ff.phys_start;
         pend_pages_in = in_data_ff.page_count;
      end

      new_rsp.out_type  = pend_type_in;
      new_rsp.out_attr  = pend_attr_in;
      new_rsp.out_start = pend_start_in;
      new_rsp.out_pages = pend_pages_in;
      new_rsp.out_last  = 1'b1;

      if (go) begin
         if (!protect_ff) begin
            pend_valid_in = 1'b0;
            pend_type_in  = pend_type_ff;
            pend_attr_in  = pend_attr_ff;
            pend_start_in = pend_start_ff;
            pend_pages_in = pend_pages_ff;
            push.first    = pend_valid_ff ? old_rsp : pass_rsp;
            push.second   = pass_rsp;
            push.count    = pend_valid_ff ? 2'd2 : 2'd1;
         end else begin
            pend_valid_in = ~in_data_ff.last_entry;
            push.first    = emit_old ? old_rsp : new_rsp;
            push.second   = new_rsp;
            push.count    = {1'b0, emit_old} + {1'b0, in_data_ff.last_entry};
         end
      end else begin
         pend_type_in  = pend_type_ff;
         pend_attr_in  = pend_attr_ff;
         pend_start_in = pend_start_ff;
         pend_pages_in = pend_pages_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         protect_ff    <= 1'b1;
         rtc_type_ff   <= mmac_pkg::RUNTIME_CODE_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         pend_valid_ff <= pend_valid_in;
         if (csr_we) begin
            case (csr_addr)
               mmac_pkg::CSR_PROTECT_ENABLE:    protect_ff  <= csr_wdata[0];
               mmac_pkg::CSR_RUNTIME_CODE_TYPE: rtc_type_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      pend_type_ff  <= pend_type_in;
      pend_attr_ff  <= pend_attr_in;
      pend_start_ff <= pend_start_in;
      pend_pages_ff <= pend_pages_in;
   end

endmodule
`default_nettype wire

// File: rtl/mmac_out_queue.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on mmac_pkg.
`default_nettype none
module mmac_out_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mmac_pkg::push_type push,
   output logic                    room,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output mmac_pkg::rsp_type       rsp_data
);

   mmac_pkg::rsp_type                  mem_ff [mmac_pkg::OUT_DEPTH];
   logic [mmac_pkg::OUT_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [mmac_pkg::OUT_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [mmac_pkg::OUT_CNT_W-1:0]     count_ff, count_in;
   logic [mmac_pkg::OUT_PTR_W-1:0]     wr_ptr_next;
   logic                               pop;

   assign room        = count_ff <= mmac_pkg::OUT_CNT_W'(mmac_pkg::OUT_DEPTH - 2);
   assign rsp_valid   = count_ff != '0;
   assign rsp_data    = mem_ff[rd_ptr_ff];
   assign pop         = rsp_valid & rsp_ready;
   assign wr_ptr_next = wr_ptr_ff + mmac_pkg::OUT_PTR_W'(1);
   assign wr_ptr_in   = wr_ptr_ff + mmac_pkg::OUT_PTR_W'(push.count);
   assign rd_ptr_in   = rd_ptr_ff + mmac_pkg::OUT_PTR_W'(pop);
   assign count_in    = count_ff + mmac_pkg::OUT_CNT_W'(push.count)
                        - mmac_pkg::OUT_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

endmodule
`default_nettype wire

// File: rtl/memory_map_attribute_coalescer.sv
// Top level of the memory map attribute coalescer.
// Connects mmac_core and mmac_out_queue; depends on mmac_pkg.
//
// Descriptors enter on req_ and merged descriptors leave on rsp_ (passed through
// unmerged while protection is off). One descriptor is taken per cycle while the core
// stage is not held: the merge compare and page add against the pending descriptor
// are done in the core stage. A descriptor yields zero, one or two results; results
// wait in a four-entry queue and leave one per transfer, and the core stage holds
// while the queue has fewer than two free entries. A descriptor is registered at the
// core stage input, and its results are registered in the queue before they transfer.
// Write the csr_ registers only while the block is idle.
`default_nettype none
module memory_map_attribute_coalescer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire mmac_pkg::req_type       req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output mmac_pkg::rsp_type            rsp_data,
   input  wire logic                    csr_we,
   input  wire mmac_pkg::csr_index_type csr_addr,
   input  wire logic [31:0]             csr_wdata
);

   mmac_pkg::push_type push;
   logic               room;

   mmac_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .room      (room),
      .push      (push)
   );

   mmac_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// File: rtl/mmac_checker.sv
// Port-level checks for memory_map_attribute_coalescer, and the bind that attaches them.
// Depends on mmac_pkg.
`default_nettype none
module mmac_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire mmac_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("block not empty after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result waiting");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with the result queue empty");

endmodule

bind memory_map_attribute_coalescer mmac_checker u_mmac_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
